### sv/hsv_to_rgb_8bit_converter_top_macros.svh
// assertion macros shared by the converter checker
`ifndef HSV_TO_RGB_8BIT_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_8BIT_CONVERTER_TOP_MACROS_SVH

// checked on every rising edge outside reset
`define HSVRGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/hsvrgb_pkg.sv
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_t;

  // sector and in-sector fraction from the hue decode
  typedef struct packed {
    logic [2:0] sector;
    logic [7:0] frac;
  } sect_t;

  localparam logic [7:0] HSV_FULL  = 8'd255;
  localparam int unsigned HSV_THIRD = 85;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

endpackage

### sv/hsvrgb_sector.sv
// hue decode: sector by threshold compare, fraction from the remainder
`timescale 1ns / 1ps

module hsvrgb_sector (
  input  logic [7:0]         hue,
  output hsvrgb_pkg::sect_t  sect
);
  import hsvrgb_pkg::*;

  // sector = floor(2*hue / 85), thresholds on the doubled hue
  localparam logic [8:0] THR1 = 9'(1 * HSV_THIRD);
  localparam logic [8:0] THR2 = 9'(2 * HSV_THIRD);
  localparam logic [8:0] THR3 = 9'(3 * HSV_THIRD);
  localparam logic [8:0] THR4 = 9'(4 * HSV_THIRD);
  localparam logic [8:0] THR5 = 9'(5 * HSV_THIRD);
  localparam logic [8:0] THR6 = 9'(6 * HSV_THIRD);

  logic [8:0] h2;
  logic [8:0] base;
  logic [8:0] rem9;
  logic [6:0] rem;
  logic [2:0] sec;

  always_comb begin
    h2 = {hue, 1'b0};
    // top of the circle folds back onto the first sector
    priority if (h2 >= THR6) begin
      sec  = SECTOR_0;
      base = THR6;
    end else if (h2 >= THR5) begin
      sec  = SECTOR_5;
      base = THR5;
    end else if (h2 >= THR4) begin
      sec  = SECTOR_4;
      base = THR4;
    end else if (h2 >= THR3) begin
      sec  = SECTOR_3;
      base = THR3;
    end else if (h2 >= THR2) begin
      sec  = SECTOR_2;
      base = THR2;
    end else if (h2 >= THR1) begin
      sec  = SECTOR_1;
      base = THR1;
    end else begin
      sec  = SECTOR_0;
      base = 9'd0;
    end
    rem9 = h2 - base;
    // remainder stays below 85
    rem  = rem9[6:0];
    sect.sector = sec;
    sect.frac   = {rem, 1'b0} + {1'b0, rem};
  end

endmodule

### sv/hsv_to_rgb_8bit_converter_top.sv
// hsv to rgb converter top level: three-stage pipeline with valid/ready
`timescale 1ns / 1ps

//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------
//  hsv     | in  | hsv_valid / hsv_ready | hue, saturation, brightness (8b each)
//  rgb     | out | rgb_valid / rgb_ready | red_out, green_out, blue_out (8b each)
//
//  one item enters per cycle while hsv_ready is high; an accepted item passes
//  through three register stages in order before it shows on rgb: decode,
//  first multiply rank, second
//  multiply rank with the sector select into the output register
//  each stage holds its item while the next one is full and not moving, and
//  takes a new item whenever it is empty or moving, so bubbles close up
//  synchronous reset empties every stage; payload registers are not reset

module hsv_to_rgb_8bit_converter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               hsv_valid,
  output logic               hsv_ready,
  input  hsvrgb_pkg::hsv_t   hsv,
  output logic               rgb_valid,
  input  logic               rgb_ready,
  output hsvrgb_pkg::rgb_t   rgb
);
  import hsvrgb_pkg::*;

  // stage 1: sector decode
  sect_t       sect_dec;
  logic        s1_valid;
  logic [2:0]  s1_sector;
  logic [7:0]  s1_frac;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_bri;
  logic        s1_gray;

  // stage 2: p level and the two saturation-scaled fractions
  logic        s2_valid;
  logic [2:0]  s2_sector;
  logic [7:0]  s2_bri;
  logic        s2_gray;
  logic [7:0]  s2_p;
  logic [7:0]  s2_sf;
  logic [7:0]  s2_sfn;

  // stage 3 is the output register
  rgb_t        rgb_next;

  logic        s1_ready;
  logic        s2_ready;
  logic        s3_ready;

  logic [15:0] p_prod;
  logic [15:0] sf_prod;
  logic [15:0] sfn_prod;
  logic [15:0] q_prod;
  logic [15:0] t_prod;
  logic [7:0]  q_lvl;
  logic [7:0]  t_lvl;

  // a stage can take an item when it is empty or its item moves on
  assign s3_ready  = !rgb_valid || rgb_ready;
  assign s2_ready  = !s2_valid  || s3_ready;
  assign s1_ready  = !s1_valid  || s2_ready;
  assign hsv_ready = s1_ready;

  hsvrgb_sector u_sector (
    .hue  (hsv.hue),
    .sect (sect_dec)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= hsv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && hsv_valid) begin
      s1_sector <= sect_dec.sector;
      s1_frac   <= sect_dec.frac;
      s1_sat    <= hsv.saturation;
      s1_bri    <= hsv.brightness;
      s1_gray   <= (hsv.saturation == 8'd0);
    end
  end

  // first multiply rank: v*(255-s), s*frac, s*(255-frac)
  assign p_prod   = {8'd0, s1_bri} * {8'd0, HSV_FULL - s1_sat};
  assign sf_prod  = {8'd0, s1_sat} * {8'd0, s1_frac};
  assign sfn_prod = {8'd0, s1_sat} * {8'd0, HSV_FULL - s1_frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_sector <= s1_sector;
      s2_bri    <= s1_bri;
      s2_gray   <= s1_gray;
      s2_p      <= p_prod[15:8];
      s2_sf     <= sf_prod[15:8];
      s2_sfn    <= sfn_prod[15:8];
    end
  end

  // second multiply rank: q falls across the sector, t rises
  assign q_prod = {8'd0, s2_bri} * {8'd0, HSV_FULL - s2_sf};
  assign t_prod = {8'd0, s2_bri} * {8'd0, HSV_FULL - s2_sfn};
  assign q_lvl  = q_prod[15:8];
  assign t_lvl  = t_prod[15:8];

  // route v, p, q, t by sector; zero saturation gives gray at v
  always_comb begin
    if (s2_gray) begin
      rgb_next = '{red_out: s2_bri, green_out: s2_bri, blue_out: s2_bri};
    end else begin
      unique case (s2_sector)
        SECTOR_1: rgb_next = '{red_out: q_lvl,  green_out: s2_bri, blue_out: s2_p};
        SECTOR_2: rgb_next = '{red_out: s2_p,   green_out: s2_bri, blue_out: t_lvl};
        SECTOR_3: rgb_next = '{red_out: s2_p,   green_out: q_lvl,  blue_out: s2_bri};
        SECTOR_4: rgb_next = '{red_out: t_lvl,  green_out: s2_p,   blue_out: s2_bri};
        SECTOR_5: rgb_next = '{red_out: s2_bri, green_out: s2_p,   blue_out: q_lvl};
        default:  rgb_next = '{red_out: s2_bri, green_out: t_lvl,  blue_out: s2_p};
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (s3_ready) begin
      rgb_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      rgb <= rgb_next;
    end
  end

endmodule

### sv/hsvrgb_checker.sv
// port-level checker for the converter, bound to the top level
`timescale 1ns / 1ps
`include "hsv_to_rgb_8bit_converter_top_macros.svh"

module hsvrgb_checker (
  input logic              clk,
  input logic              rst,
  input logic              hsv_valid,
  input logic              hsv_ready,
  input logic              rgb_valid,
  input logic              rgb_ready,
  input hsvrgb_pkg::rgb_t  rgb
);
  import hsvrgb_pkg::*;

  // items accepted and not yet delivered
  logic [2:0] inflight;
  logic [2:0] inflight_next;

  always_comb begin
    inflight_next = inflight;
    if (hsv_valid && hsv_ready) begin
      inflight_next = inflight_next + 3'd1;
    end
    if (rgb_valid && rgb_ready) begin
      inflight_next = inflight_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `HSVRGB_ASSERT(a_out_hold, rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb), "rgb item changed while stalled")
  `HSVRGB_ASSERT(a_depth, inflight <= 3'd3, "more items in flight than pipeline stages")
  `HSVRGB_ASSERT(a_no_phantom, rgb_valid |-> inflight != 3'd0, "rgb item with no accepted item behind it")
  `HSVRGB_ASSERT(a_no_bubble_stall, inflight < 3'd3 |-> hsv_ready, "input stalled with a free stage")
  `HSVRGB_ASSERT_ALWAYS(a_reset_empty, rst |=> !rgb_valid && hsv_ready, "pipeline not empty after reset")

endmodule

bind hsv_to_rgb_8bit_converter_top hsvrgb_checker u_hsvrgb_checker (
  .clk       (clk),
  .rst       (rst),
  .hsv_valid (hsv_valid),
  .hsv_ready (hsv_ready),
  .rgb_valid (rgb_valid),
  .rgb_ready (rgb_ready),
  .rgb       (rgb)
);

### verif/hsv_to_rgb_8bit_converter_top_tb.sv
// testbench for the hsv to rgb converter: predicts each color triple and checks the rgb stream
`timescale 1ns / 1ps

module hsv_to_rgb_8bit_converter_top_tb;
  import hsvrgb_pkg::*;

  localparam int IDLE_LIMIT      = 2000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES     = 60;    // long receiver stall, far beyond the pipeline depth
  localparam int ITEMS_PER_PHASE = 500;
  localparam int SETTLE_CYCLES   = 10;    // pipeline is three stages deep
  localparam int MAX_PRINTS      = 50;

  // expected rgb triples in arrival order, with a bit-exact converter model
  class rgb_checker;
    rgb_t pending_rgb[$];
    int   mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // truncating 8x8 multiply, upper byte kept
    function logic [7:0] scale8(logic [7:0] a, logic [7:0] b);
      logic [15:0] prod;
      prod = a * b;
      return prod[15:8];
    endfunction

    function rgb_t predict_rgb(hsv_t x);
      logic [7:0] v, p, q, t, frac;
      logic [2:0] sec;
      rgb_t       y;
      v = x.brightness;
      // gray when saturation is zero
      if (x.saturation == 8'd0) begin
        y = '{v, v, v};
        return y;
      end
      // sector 0..6, hue 255 lands in sector 6 and falls to the default arm
      sec  = 3'((int'(x.hue) * 6) / int'(HSV_FULL));
      frac = 8'(((int'(x.hue) * 2) - int'(sec) * int'(HSV_THIRD)) * 3);
      p = scale8(v, HSV_FULL - x.saturation);
      q = scale8(v, HSV_FULL - scale8(x.saturation, frac));
      t = scale8(v, HSV_FULL - scale8(x.saturation, HSV_FULL - frac));
      case (sec)
        SECTOR_1: y = '{q, v, p};
        SECTOR_2: y = '{p, v, t};
        SECTOR_3: y = '{p, q, v};
        SECTOR_4: y = '{t, p, v};
        SECTOR_5: y = '{v, p, q};
        default:  y = '{v, t, p};
      endcase
      return y;
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    function void note_hsv(hsv_t x);
      pending_rgb.push_back(predict_rgb(x));
    endfunction

    task check_rgb(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red_out !== want.red_out)
        report_mismatch($sformatf("red_out %0d, want %0d", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report_mismatch($sformatf("green_out %0d, want %0d", got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
        report_mismatch($sformatf("blue_out %0d, want %0d", got.blue_out, want.blue_out));
    endtask

    function int pending();
      return pending_rgb.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic hsv_valid = 1'b0;
  logic hsv_ready;
  hsv_t hsv       = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  rgb_t rgb;

  rgb_checker  sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          idle_cycles   = 0;

  hsv_to_rgb_8bit_converter_top uut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels sampled at the edge, so values seen are the pre-edge ones
  always @(posedge clk) begin
    if (!rst) begin
      if (hsv_valid && hsv_ready) sb.note_hsv(hsv);
      if (rgb_valid && rgb_ready) sb.check_rgb(rgb);
    end
  end

  // watchdog: no item moving on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst) begin
      if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request so the pipe backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rgb_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rgb_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // offer one item, with random gaps before it, and wait until it is taken
  task automatic send_hsv(input hsv_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hsv_valid <= 1'b0;
      @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hsv       <= item;
    @(posedge clk);
    while (!hsv_ready) @(posedge clk);
  endtask

  // sender goes quiet until every outstanding triple has come back
  task automatic drain_rgb();
    hsv_valid <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random triple, with extra weight on gray and on the channel extremes
  function automatic hsv_t random_hsv();
    hsv_t x;
    x.hue = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       x.saturation = 8'd0;
      1:       x.saturation = HSV_FULL;
      default: x.saturation = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       x.brightness = 8'd0;
      1:       x.brightness = HSV_FULL;
      default: x.brightness = 8'($urandom_range(0, 255));
    endcase
    return x;
  endfunction

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) hold_req = 1'b1;
    repeat (ITEMS_PER_PHASE) send_hsv(random_hsv());
    drain_rgb();
  endtask

  initial begin
    // hues at both sides of the sector boundaries at 43, 128 and 213, the first hue of the others, and the wrap at 255
    logic [7:0] corner_hues[11];
    corner_hues = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd127, 8'd128,
                    8'd170, 8'd212, 8'd213, 8'd254, 8'd255};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items, no stalls
    foreach (corner_hues[i]) send_hsv(hsv_t'{corner_hues[i], HSV_FULL, HSV_FULL});
    // gray at several levels, hue must not matter
    send_hsv(hsv_t'{8'd200, 8'd0, 8'd0});
    send_hsv(hsv_t'{8'd255, 8'd0, HSV_FULL});
    send_hsv(hsv_t'{8'd17, 8'd0, 8'd100});
    // smallest nonzero saturation and value
    send_hsv(hsv_t'{8'd255, 8'd1, HSV_FULL});
    send_hsv(hsv_t'{8'd0, 8'd1, 8'd1});
    send_hsv(hsv_t'{8'd128, 8'd128, 8'd0});
    send_hsv(hsv_t'{8'd255, HSV_FULL, 8'd128});
    send_hsv(hsv_t'{8'd100, HSV_FULL, 8'd1});
    send_hsv(hsv_t'{8'd190, 8'd254, 8'd254});
    drain_rgb();

    // busy sender with a mostly stalled receiver, then the reverse, then full rate with one long receiver hold-off
    run_phase(26, 87, 1'b0);
    run_phase(87, 26, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hsvrgb_pkg.sv
sv/hsvrgb_sector.sv
sv/hsv_to_rgb_8bit_converter_top.sv
sv/hsvrgb_checker.sv
verif/hsv_to_rgb_8bit_converter_top_tb.sv
